### rtl/core/tceb_pkg.sv
// ----------------------------------------------------------------------------
// tceb_pkg
// Shared types and constants of the timestamp coincidence event builder.
// ----------------------------------------------------------------------------
package tceb_pkg;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_BUILD = 1'b1;

  localparam logic [15:0] WINDOW_RESET = 16'd220;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  source;
    logic [31:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [31:0] group_number;
    logic [1:0]  member_source;
    logic [31:0] member_time;
    logic        group_end;
    logic        last;
    logic        overflow_seen;
  } out_word_t;

endpackage

### rtl/core/timestamp_coincidence_event_builder_unit.sv
// ----------------------------------------------------------------------------
// timestamp_coincidence_event_builder_unit
// Per-source timestamp queues in one memory, drained into coincidence groups.
// ----------------------------------------------------------------------------
//  channel | signals                         | role
//  --------+---------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data     | push or build request word
//  out     | out_valid, out_ready, out_data  | one emitted event word
//  cfg     | cfg_valid, cfg_ready, cfg_data  | coincidence window register
//
//  Pushes may arrive every cycle while the unit is idle.
//  A build walks the memory one read at a time. Per group: read and compare
//  the head of each non-empty source to find the anchor, then take it; read
//  and compare the heads that do not join; read, compare and hand off each
//  joining member. One word is held back until the next event or the group
//  end is known, so group_end and last are exact.
//  The single read port of the timestamp memory sets the pace of the walk.
//  Reset is synchronous; queues start empty, no clearing pass is needed.
//  A stalled output holds the walk; no input is taken during a build.
// ----------------------------------------------------------------------------
module timestamp_coincidence_event_builder_unit #(
  parameter int NUM_SOURCES = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tceb_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tceb_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int SW   = 2;
  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int AW   = SW + PW;
  localparam int SUMW = CW + 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_AREAD  = 7'b0000010,
    ST_ACMP   = 7'b0000100,
    ST_AEMIT  = 7'b0001000,
    ST_MREAD  = 7'b0010000,
    ST_MCMP   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t state, ret_state;

  logic [PW-1:0] heads  [NUM_SOURCES];
  logic [CW-1:0] counts [NUM_SOURCES];
  logic [31:0]   group_counter;
  logic          overflow_flag;
  logic [15:0]   window;

  logic [SW-1:0] scan;          // source being read
  logic [SW-1:0] best;
  logic [31:0]   anchor;
  logic          found;
  logic [31:0]   grp;

  // word held back until we know whether it closes its group
  logic          hold_valid;
  logic [SW-1:0] hold_source;
  logic [31:0]   hold_time;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   rd_data;
  logic [SUMW-1:0] wsum;
  logic [PW-1:0]   wpos;

  // advance a read position, wrapping at the queue depth
  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  logic push_ok;
  logic [31:0] diff;
  logic        joins;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  assign push_ok = in_valid && in_ready && (in_data.req_type == tceb_pkg::REQ_PUSH)
                   && (32'(in_data.source) < NUM_SOURCES)
                   && (counts[in_data.source[SW-1:0]] < CW'(QUEUE_DEPTH));

  always_comb begin
    // tail slot = head + count, wrapped at the queue depth
    wsum = SUMW'(heads[in_data.source]) + SUMW'(counts[in_data.source]);
    if (wsum >= SUMW'(QUEUE_DEPTH)) begin
      wpos = PW'(wsum - SUMW'(QUEUE_DEPTH));
    end else begin
      wpos = PW'(wsum);
    end
    wr_en   = push_ok;
    wr_addr = {in_data.source, wpos};
    rd_en   = (state == ST_AREAD) || (state == ST_MREAD);
    rd_addr = {scan, heads[scan]};
  end

  assign diff  = rd_data - anchor;
  assign joins = diff[31] || (diff < {16'd0, window});

  tceb_store #(.AW(AW)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data(in_data.timestamp),
    .rd_en, .rd_addr, .rd_data
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ret_state     <= ST_IDLE;
      group_counter <= '0;
      overflow_flag <= 1'b0;
      window        <= tceb_pkg::WINDOW_RESET;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
      scan       <= '0;
      found      <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            window <= cfg_data;
          end
          if (in_valid) begin
            if (in_data.req_type == tceb_pkg::REQ_PUSH) begin
              if (push_ok) begin
                counts[in_data.source] <= counts[in_data.source] + CW'(1);
              end else if (32'(in_data.source) < NUM_SOURCES) begin
                overflow_flag <= 1'b1;
              end
            end else begin
              // start a group search
              scan       <= '0;
              found      <= 1'b0;
              anchor     <= '1;
              hold_valid <= 1'b0;
              state      <= ST_AREAD;
            end
          end
        end
        ST_AREAD: begin
          // read always issued; its data is used only if this source is not empty
          if (counts[scan] != '0) begin
            state <= ST_ACMP;
          end else if (32'(scan) == NUM_SOURCES - 1) begin
            state <= ST_AEMIT;
          end else begin
            scan <= scan + SW'(1);
          end
        end
        ST_ACMP: begin
          if (rd_data <= anchor) begin
            anchor <= rd_data;
            best   <= scan;
            found  <= 1'b1;
          end
          if (32'(scan) == NUM_SOURCES - 1) begin
            state <= ST_AEMIT;
          end else begin
            scan  <= scan + SW'(1);
            state <= ST_AREAD;
          end
        end
        ST_AEMIT: begin
          if (found) begin
            // take the anchor; the held word closed the previous group
            grp           <= group_counter;
            group_counter <= group_counter + 32'd1;
            heads[best]   <= next_pos(heads[best]);
            counts[best]  <= counts[best] - CW'(1);
            hold_source   <= best;
            hold_time     <= anchor;
            hold_valid    <= 1'b1;
            scan          <= '0;
            if (hold_valid) begin
              out_data  <= '{grp, hold_source, hold_time, 1'b1, 1'b0, overflow_flag};
              ret_state <= ST_MREAD;
              state     <= ST_OUT;
            end else begin
              state <= ST_MREAD;
            end
          end else if (hold_valid) begin
            // queues drained: the held word ends the run
            out_data   <= '{grp, hold_source, hold_time, 1'b1, 1'b1, overflow_flag};
            hold_valid <= 1'b0;
            ret_state  <= ST_IDLE;
            state      <= ST_OUT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MREAD: begin
          if (counts[scan] != '0) begin
            state <= ST_MCMP;
          end else if (32'(scan) == NUM_SOURCES - 1) begin
            scan   <= '0;
            found  <= 1'b0;
            anchor <= '1;
            state  <= ST_AREAD;
          end else begin
            scan <= scan + SW'(1);
          end
        end
        ST_MCMP: begin
          if (joins) begin
            // a member joins: release the held word, hold this one
            out_data     <= '{grp, hold_source, hold_time, 1'b0, 1'b0, overflow_flag};
            hold_source  <= scan;
            hold_time    <= rd_data;
            heads[scan]  <= next_pos(heads[scan]);
            counts[scan] <= counts[scan] - CW'(1);
            ret_state    <= ST_MREAD;
            state        <= ST_OUT;
          end else if (32'(scan) == NUM_SOURCES - 1) begin
            scan   <= '0;
            found  <= 1'b0;
            anchor <= '1;
            state  <= ST_AREAD;
          end else begin
            scan  <= scan + SW'(1);
            state <= ST_MREAD;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ret_state;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state));

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data));

  a_in_out_apart: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid));

  a_push_idle: assert property (@(posedge clk) disable iff (rst) wr_en |-> in_ready);

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.group_end);

endmodule

### rtl/core/tceb_store.sv
// ----------------------------------------------------------------------------
// tceb_store
// Timestamp memory for all source queues: one write port, one registered read.
// ----------------------------------------------------------------------------
module tceb_store #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### tb/sv/tceb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tceb_checker
// Watches the request, event and window channels of the event builder,
// predicts every emitted event word and compares it field by field.
// ----------------------------------------------------------------------------
module tceb_checker #(
  parameter int NUM_SOURCES = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tceb_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tceb_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  error_count,
  output int                  pending_count
);

  logic [31:0]         ts_fifo [NUM_SOURCES][$];
  logic [31:0]         next_group;
  logic                dropped_flag;
  logic [15:0]         window_reg;
  tceb_pkg::out_word_t event_queue [$];

  task automatic build_groups();
    int                  anchor_src;
    logic [31:0]         anchor;
    logic [31:0]         diff;
    logic [31:0]         grp;
    bit                  busy;
    tceb_pkg::out_word_t ev;
    int                  first_idx;
    first_idx = event_queue.size();
    forever begin
      busy = 0;
      anchor = 32'hFFFF_FFFF;
      anchor_src = 0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        if (ts_fifo[s].size() != 0 && ts_fifo[s][0] <= anchor) begin
          anchor = ts_fifo[s][0];
          anchor_src = s;
          busy = 1;
        end
      end
      if (!busy) break;
      grp = next_group;
      next_group = next_group + 1;
      ev = '{grp, anchor_src[1:0], anchor, 1'b0, 1'b0, dropped_flag};
      event_queue.insert(event_queue.size(), ev);
      void'(ts_fifo[anchor_src].pop_front());
      for (int s = 0; s < NUM_SOURCES; s++) begin
        while (ts_fifo[s].size() != 0) begin
          diff = ts_fifo[s][0] - anchor;
          if (!(diff[31] || diff < {16'd0, window_reg})) break;
          ev = '{grp, s[1:0], ts_fifo[s][0], 1'b0, 1'b0, dropped_flag};
          event_queue.insert(event_queue.size(), ev);
          void'(ts_fifo[s].pop_front());
        end
      end
      event_queue[event_queue.size() - 1].group_end = 1'b1;
    end
    if (event_queue.size() > first_idx)
      event_queue[event_queue.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    tceb_pkg::out_word_t exp_ev;
    if (rst) begin
      for (int s = 0; s < NUM_SOURCES; s++) ts_fifo[s].delete();
      event_queue.delete();
      next_group = '0;
      dropped_flag = 1'b0;
      window_reg = tceb_pkg::WINDOW_RESET;
      error_count = 0;
      pending_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) window_reg = cfg_data;
      if (out_valid && out_ready) begin
        if (event_queue.size() == 0) begin
          $error("event word with nothing expected: %p", out_data);
          error_count = error_count + 1;
        end else begin
          exp_ev = event_queue.pop_front();
          if (out_data.group_number !== exp_ev.group_number) begin
            $error("group_number expected %0d got %0d", exp_ev.group_number,
                   out_data.group_number);
            error_count = error_count + 1;
          end
          if (out_data.member_source !== exp_ev.member_source) begin
            $error("member_source expected %0d got %0d", exp_ev.member_source,
                   out_data.member_source);
            error_count = error_count + 1;
          end
          if (out_data.member_time !== exp_ev.member_time) begin
            $error("member_time expected %h got %h", exp_ev.member_time,
                   out_data.member_time);
            error_count = error_count + 1;
          end
          if (out_data.group_end !== exp_ev.group_end) begin
            $error("group_end expected %0b got %0b", exp_ev.group_end,
                   out_data.group_end);
            error_count = error_count + 1;
          end
          if (out_data.last !== exp_ev.last) begin
            $error("last expected %0b got %0b", exp_ev.last, out_data.last);
            error_count = error_count + 1;
          end
          if (out_data.overflow_seen !== exp_ev.overflow_seen) begin
            $error("overflow_seen expected %0b got %0b", exp_ev.overflow_seen,
                   out_data.overflow_seen);
            error_count = error_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == tceb_pkg::REQ_PUSH) begin
          if (in_data.source < NUM_SOURCES) begin
            if (ts_fifo[in_data.source].size() >= QUEUE_DEPTH) dropped_flag = 1'b1;
            else ts_fifo[in_data.source].insert(ts_fifo[in_data.source].size(),
                                                in_data.timestamp);
          end
        end else begin
          build_groups();
        end
      end
      pending_count = event_queue.size();
    end
  end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push and build words plus window writes into the event builder and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  tceb_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tceb_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_data;
  int                  error_count;
  int                  pending_count;
  int                  cycle_count = 0;
  bit                  stall_enable;

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  timestamp_coincidence_event_builder_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  tceb_checker checker_inst (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .error_count(error_count), .pending_count(pending_count)
  );

  // Gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Hard stop on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver side: drop ready at random while stalling is enabled.
  always @(negedge clk) begin
    if (rst || !stall_enable) out_ready <= 1'b1;
    else if ($urandom_range(99) < 30) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  // Present one word, hold it until taken, then lower valid unless gapless.
  task automatic send_word(input logic req, input logic [1:0] src, input logic [31:0] ts,
                           input bit gapped);
    int gap;
    in_data <= '{req, src, ts};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = gapped ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic close_word();
    in_valid <= 1'b0;
  endtask

  // Hold until every predicted event word has come out, then let the walk settle.
  task automatic drain_events();
    close_word();
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_window(input logic [15:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_ts(input logic [1:0] src, input logic [31:0] ts);
    send_word(tceb_pkg::REQ_PUSH, src, ts, 1'b1);
  endtask

  task automatic build_all();
    send_word(tceb_pkg::REQ_BUILD, 2'($urandom_range(3)), $urandom, 1'b1);
  endtask

  // One random burst of pushes clustered around a base, then a build.
  task automatic random_burst(input int pushes);
    logic [31:0] base;
    logic [31:0] spread;
    base = $urandom;
    spread = 32'd1 << $urandom_range(12);
    for (int k = 0; k < pushes; k++) begin
      if ($urandom_range(19) == 0)
        push_ts(2'($urandom_range(3)), $urandom);
      else
        push_ts(2'($urandom_range(3)), base + ($urandom % spread) - (spread >> 1));
    end
    build_all();
  endtask

  initial begin
    int window_pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    stall_enable = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: build on empty queues, extremes, ties and wrap of the difference.
    build_all();
    push_ts(2'd0, 32'h0000_0000);
    push_ts(2'd3, 32'hFFFF_FFFF);
    push_ts(2'd1, 32'h0000_0064);
    push_ts(2'd2, 32'h0000_0064);
    push_ts(2'd1, 32'h8000_0000);
    build_all();
    // Tie on the anchor goes to the highest source.
    push_ts(2'd0, 32'h0000_1000);
    push_ts(2'd2, 32'h0000_1000);
    push_ts(2'd3, 32'h0000_1000);
    build_all();
    drain_events();

    // Window at zero: only negative differences join.
    write_window(16'd0);
    push_ts(2'd1, 32'h0000_0500);
    push_ts(2'd0, 32'h0000_0500);
    push_ts(2'd2, 32'h0000_0501);
    build_all();
    drain_events();

    // Window at maximum, then overflow one queue.
    write_window(16'hFFFF);
    for (int k = 0; k < 18; k++) push_ts(2'd2, 32'h0001_0000 + k);
    push_ts(2'd1, 32'h0001_FFFE);
    build_all();
    drain_events();

    // Random phases with different windows; sender holds off between them.
    stall_enable = 1;
    for (int phase = 0; phase < 6; phase++) begin
      window_pick = $urandom_range(3);
      if (window_pick == 0) write_window(16'd0);
      else if (window_pick == 1) write_window(16'hFFFF);
      else write_window(16'($urandom));
      for (int b = 0; b < 3; b++) random_burst($urandom_range(10, 2));
      drain_events();
      if (phase == 2) stall_enable = 0;
      if (phase == 3) stall_enable = 1;
    end
    write_window(tceb_pkg::WINDOW_RESET);
    random_burst(12);
    drain_events();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/tceb_pkg.sv
rtl/core/tceb_store.sv
rtl/core/timestamp_coincidence_event_builder_unit.sv
tb/sv/tceb_checker.sv
tb/sv/testbench.sv
